FILE: rtl/core/bchd_pkg.sv
package bchd_pkg;

  localparam int unsigned IDX_W   = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_W-1:0] IGNORE_RST = 16'd50;
  localparam logic [CFG_W-1:0] MULTI_RST  = 16'd250;
  localparam logic [CFG_W-1:0] HOLD_RST   = 16'd3000;

  typedef enum logic [1:0] {
    REG_IGNORE = 2'd0,
    REG_MULTI  = 2'd1,
    REG_HOLD   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CLICKS  = 2'd2,
    EV_HOLD    = 2'd3
  } event_kind_e;

  typedef struct packed {
    logic [CFG_W-1:0] ignore_ms;
    logic [CFG_W-1:0] multi_click_ms;
    logic [CFG_W-1:0] hold_ms;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    event_kind_e        kind;
    logic [COUNT_W-1:0] count;
  } lane_evt_t;

endpackage

FILE: rtl/core/bchd_in_if.sv
interface bchd_in_if #(
  parameter int unsigned NUM_BUTTONS = 5
);
  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] button_bits;
  logic [31:0]            now_ms;

  modport source (output valid, output button_bits, output now_ms, input ready);
  modport sink (input valid, input button_bits, input now_ms, output ready);
endinterface

FILE: rtl/core/bchd_out_if.sv
interface bchd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] button_index;
  logic [1:0] event_kind;
  logic [7:0] click_count;
  logic       last_event;

  modport source (output valid, output button_index, output event_kind,
                  output click_count, output last_event, input ready);
  modport sink (input valid, input button_index, input event_kind,
                input click_count, input last_event, output ready);
endinterface

FILE: rtl/core/bchd_lane.sv
module bchd_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                pushed_i,
  input  logic [31:0]         now_i,
  input  bchd_pkg::cfg_t      cfg_i,
  output bchd_pkg::lane_evt_t evt_o
);
  import bchd_pkg::*;

  logic               down_q, down_d;
  logic [TIME_W-1:0]  press_time_q, press_time_d;
  logic               press_valid_q, press_valid_d;
  logic [TIME_W-1:0]  rel_time_q, rel_time_d;
  logic               rel_valid_q, rel_valid_d;
  logic [COUNT_W-1:0] rel_count_q, rel_count_d;

  logic [TIME_W-1:0] since_rel, since_press;
  logic press, release_ev, close, hold;

  assign since_rel   = now_i - rel_time_q;
  assign since_press = now_i - press_time_q;

  // release time only moves to now on a release, which then cannot close the run
  always_comb begin
    press      = pushed_i && !down_q &&
                 !(rel_valid_q && (since_rel < {{(TIME_W-CFG_W){1'b0}}, cfg_i.ignore_ms}));
    release_ev = !pushed_i && down_q;
    close      = rel_valid_q && !down_q && !press &&
                 (since_rel > {{(TIME_W-CFG_W){1'b0}}, cfg_i.multi_click_ms});
    hold       = pushed_i && down_q && press_valid_q &&
                 (since_press > {{(TIME_W-CFG_W){1'b0}}, cfg_i.hold_ms});

    evt_o.valid = 1'b0;
    evt_o.kind  = EV_PRESS;
    evt_o.count = '0;
    if (press) begin
      evt_o.valid = 1'b1;
      evt_o.kind  = EV_PRESS;
    end else if (release_ev) begin
      evt_o.valid = 1'b1;
      evt_o.kind  = EV_RELEASE;
    end else if (close && press_valid_q) begin
      evt_o.valid = 1'b1;
      evt_o.kind  = EV_CLICKS;
      evt_o.count = rel_count_q;
    end else if (hold) begin
      evt_o.valid = 1'b1;
      evt_o.kind  = EV_HOLD;
    end

    down_d        = (down_q || press) && !release_ev;
    press_time_d  = press ? now_i : press_time_q;
    press_valid_d = (press_valid_q || press) && !hold;
    rel_time_d    = release_ev ? now_i : rel_time_q;
    rel_valid_d   = (rel_valid_q || release_ev) && !close;
    if (close) begin
      rel_count_d = '0;
    end else if (release_ev && rel_count_q != COUNT_MAX) begin
      rel_count_d = rel_count_q + COUNT_W'(1);
    end else begin
      rel_count_d = rel_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q        <= 1'b0;
      press_time_q  <= '0;
      press_valid_q <= 1'b0;
      rel_time_q    <= '0;
      rel_valid_q   <= 1'b0;
      rel_count_q   <= '0;
    end else if (step_i) begin
      down_q        <= down_d;
      press_time_q  <= press_time_d;
      press_valid_q <= press_valid_d;
      rel_time_q    <= rel_time_d;
      rel_valid_q   <= rel_valid_d;
      rel_count_q   <= rel_count_d;
    end
  end

endmodule

FILE: rtl/core/bchd_merge.sv
module bchd_merge #(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bchd_pkg::lane_evt_t evt_i [NUM_BUTTONS],
  bchd_out_if.source          out_if
);
  import bchd_pkg::*;

  logic [NUM_BUTTONS-1:0] pend_q, pend_d;
  event_kind_e            kind_q  [NUM_BUTTONS];
  logic [COUNT_W-1:0]     count_q [NUM_BUTTONS];

  logic               ovalid_q, ovalid_d;
  logic [IDX_W-1:0]   oidx_q;
  event_kind_e        okind_q;
  logic [COUNT_W-1:0] ocount_q;
  logic               olast_q;

  logic [NUM_BUTTONS-1:0] sel_oh, rest, new_mask;
  logic [IDX_W-1:0]       sel_idx;
  logic                   load, accept;

  always_comb begin
    sel_idx = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (pend_q[i]) sel_idx = IDX_W'(i);
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      new_mask[i] = evt_i[i].valid;
    end
  end

  assign sel_oh     = pend_q & (~pend_q + NUM_BUTTONS'(1));
  assign rest       = pend_q & ~sel_oh;
  assign load       = (pend_q != '0) && (!ovalid_q || out_if.ready);
  assign in_ready_o = (pend_q == '0) || ((rest == '0) && load);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = new_mask;
    end else if (load) begin
      pend_d = rest;
    end
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (out_if.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        kind_q[i]  <= evt_i[i].kind;
        count_q[i] <= evt_i[i].count;
      end
    end
    if (load) begin
      oidx_q   <= sel_idx;
      okind_q  <= kind_q[sel_idx];
      ocount_q <= count_q[sel_idx];
      olast_q  <= (rest == '0);
    end
  end

  assign out_if.valid        = ovalid_q;
  assign out_if.button_index = oidx_q;
  assign out_if.event_kind   = okind_q;
  assign out_if.click_count  = ocount_q;
  assign out_if.last_event   = olast_q;

  // a new sample only lands once the previous one has fully drained
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ((pend_q & ~(load ? sel_oh : '0)) == '0))
    else $error("sample accepted over pending beats");

  // each load retires exactly one pending beat
  a_load_retires_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !accept) |=> ($countones(pend_q) + 1 == $countones($past(pend_q))))
    else $error("pending mask lost or kept a beat");

  // a beat not marked last must leave more behind it
  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_if.ready && !olast_q) |-> (pend_q != '0))
    else $error("beat without last flag but nothing pending");

endmodule

FILE: rtl/core/button_click_hold_detector.sv
// button click / hold detector
// in_if  : one beat per sample of the button bitmask with its ms timestamp
// out_if : one beat per event (button index, kind, click count, last flag);
//          a sample gives zero to NUM_BUTTONS beats, the final one flagged last
// config : apb-style port, ignore_ms at 0x0, multi_click_ms at 0x4,
//          hold_ms at 0x8, low 16 bits kept; pready is tied high
// one lane per button evaluates press, release, run close and hold in the
// accept cycle and updates its state; the merge stage queues the events of
// the sample and sends them lowest button first, one beat per cycle
// a sample's events are registered in the event queue and then loaded into
// the output register, from which its first beat can be taken
// the single output register drains the queued events one per cycle while
// the receiver is ready
// the next sample is taken in the same cycle as the last beat of the
// previous one is loaded, so back-to-back samples need no gap
// receiver stall: beats hold in the output register, queued events wait
// and no further sample is taken until the queue has drained
// reset: all buttons released with no run or press pending, registers at
// ignore 50, multi-click 250, hold 3000 ms
module button_click_hold_detector #(
  parameter int unsigned NUM_BUTTONS = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bchd_in_if.sink                       in_if,
  bchd_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bchd_pkg::ADDR_W-1:0]   paddr,
  input  logic [bchd_pkg::DATA_W-1:0]   pwdata,
  output logic [bchd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import bchd_pkg::*;

  cfg_t      cfg_q;
  lane_evt_t evt [NUM_BUTTONS];
  logic      step;
  logic      wr_en;
  reg_idx_e  reg_sel;

  // register file: word address picks the register, unknown slots ignored
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_ms      <= IGNORE_RST;
      cfg_q.multi_click_ms <= MULTI_RST;
      cfg_q.hold_ms        <= HOLD_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_IGNORE: cfg_q.ignore_ms      <= pwdata[CFG_W-1:0];
        REG_MULTI:  cfg_q.multi_click_ms <= pwdata[CFG_W-1:0];
        REG_HOLD:   cfg_q.hold_ms        <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IGNORE: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.ignore_ms};
      REG_MULTI:  prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.multi_click_ms};
      REG_HOLD:   prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.hold_ms};
      default:    prdata = '0;
    endcase
  end

  // lanes advance their state only on an accepted sample beat
  assign step = in_if.valid && in_if.ready;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bchd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .pushed_i (in_if.button_bits[b]),
      .now_i    (in_if.now_ms),
      .cfg_i    (cfg_q),
      .evt_o    (evt[b])
    );
  end

  // event queue and output register
  bchd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .evt_i      (evt),
    .out_if     (out_if)
  );

endmodule
